// File: rtl/ogbrc_pkg.sv
// package for the occupancy grid beam ray caster
// constants, cordic table and beam offsets; no dependencies
package ogbrc_pkg;
   localparam int X_CELLS_DEF   = 512;
   localparam int Y_CELLS_DEF   = 256;
   localparam int NUM_BEAMS_DEF = 5;

   localparam logic [1:0] CSR_STEP = 2'd0;
   localparam logic [1:0] CSR_MAXR = 2'd1;
   localparam logic [1:0] CSR_XLIM = 2'd2;
   localparam logic [1:0] CSR_YLIM = 2'd3;

   localparam logic [3:0] CORDIC_ITERS = 4'd15;

   function automatic logic signed [15:0] cordic_atan(input logic [3:0] i);
      case (i)
         4'd0:  cordic_atan = 16'sd8192;
         4'd1:  cordic_atan = 16'sd4836;
         4'd2:  cordic_atan = 16'sd2555;
         4'd3:  cordic_atan = 16'sd1297;
         4'd4:  cordic_atan = 16'sd651;
         4'd5:  cordic_atan = 16'sd326;
         4'd6:  cordic_atan = 16'sd163;
         4'd7:  cordic_atan = 16'sd81;
         4'd8:  cordic_atan = 16'sd41;
         4'd9:  cordic_atan = 16'sd20;
         4'd10: cordic_atan = 16'sd10;
         4'd11: cordic_atan = 16'sd5;
         4'd12: cordic_atan = 16'sd3;
         4'd13: cordic_atan = 16'sd1;
         4'd14: cordic_atan = 16'sd1;
         default: cordic_atan = 16'sd0;
      endcase
   endfunction

   function automatic logic [15:0] beam_offset(input logic [2:0] b);
      case (b)
         3'd0: beam_offset = 16'd0;
         3'd1: beam_offset = 16'd16384;
         3'd2: beam_offset = 16'd49152;
         3'd3: beam_offset = 16'd8192;
         3'd4: beam_offset = 16'd57344;
         default: beam_offset = 16'd0;
      endcase
   endfunction
endpackage

// File: rtl/occupancy_grid_beam_ray_caster_core.sv
// occupancy grid ray caster: a map write is taken while idle; a cast runs a pose check,
// then per beam cordic and setup, march steps (add, read, test),
// a range-end check and a result transfer that is held while the output stalls;
// the single grid read port and the position adder set the march rate.
// synchronous active-high reset clears control and restores register defaults;
// grid contents are undefined until written.
module occupancy_grid_beam_ray_caster_core import ogbrc_pkg::*; #(
   parameter int X_CELLS   = X_CELLS_DEF,
   parameter int Y_CELLS   = Y_CELLS_DEF,
   parameter int NUM_BEAMS = NUM_BEAMS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [11:0]        req_map_addr,
   input  logic [31:0]        req_map_data,
   input  logic signed [17:0] req_pos_x,
   input  logic signed [17:0] req_pos_y,
   input  logic [15:0]        req_heading,
   input  logic [9:0]         req_pose_tag,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_tag_out,
   output logic [2:0]         rsp_beam_index,
   output logic [17:0]        rsp_beam_range,
   output logic               rsp_beam_hit,
   output logic               rsp_last_beam
);
   localparam int WPC        = (Y_CELLS + 31) / 32;
   localparam int GRID_WORDS = X_CELLS * WPC;
   localparam int AW         = $clog2(GRID_WORDS);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PCHK  = 3'd1;  // pose cell read issued
   localparam logic [2:0] S_CORD  = 3'd2;  // waiting on cordic
   localparam logic [2:0] S_MARCH = 3'd3;  // advance position, issue read
   localparam logic [2:0] S_READ  = 3'd4;  // read data in flight
   localparam logic [2:0] S_TEST  = 3'd5;  // test occupancy bit
   localparam logic [2:0] S_OUT   = 3'd6;  // result transfer
   localparam logic [2:0] S_SETUP = 3'd7;  // step vector multiply

   logic [2:0]  st_ff, st_in;
   logic [10:0] step_ff;
   logic [16:0] maxr_ff;
   logic [9:0]  xlim_ff;
   logic [8:0]  ylim_ff;

   logic [31:0] grid [GRID_WORDS];
   logic [31:0] rd_ff;
   logic [4:0]  bit_ff, bit_in;

   logic signed [17:0] px_ff, px_in, py_ff, py_in;
   logic [15:0] hd_ff, hd_in;
   logic [9:0]  tag_ff, tag_in;
   logic        ok_ff, ok_in;
   logic [2:0]  beam_ff, beam_in;
   // ray position q22, wide enough for pose plus max range
   logic signed [39:0] x_ff, x_in, y_ff, y_in;
   logic signed [27:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [18:0] dist_ff, dist_in;  // n*step
   logic [17:0] rng_ff, rng_in;
   logic        hit_ff, hit_in;

   logic        cstart;
   logic        cdone;
   logic signed [15:0] ccos, csin;
   // marks that the pose check is done for this cast
   logic        cstart_seen_ff;

   ogbrc_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cstart),
      .angle(hd_ff + beam_offset(beam_in)),
      .done(cdone), .cos_out(ccos), .sin_out(csin)
   );

   // effective limits and step
   logic [12:0] xl, yl;
   logic [10:0] stp;
   always_comb begin
      xl  = (13'(xlim_ff) < 13'(X_CELLS)) ? 13'(xlim_ff) : 13'(X_CELLS);
      yl  = (13'(ylim_ff) < 13'(Y_CELLS)) ? 13'(ylim_ff) : 13'(Y_CELLS);
      stp = (step_ff == 11'd0) ? 11'd1 : step_ff;
   end

   // cell index: ceiling of position, shared by pose check and march
   logic signed [39:0] ax, ay, ex, ey;
   logic signed [39:0] cx, cy;
   logic        inb;
   logic [AW-1:0] raddr;
   always_comb begin
      if (st_ff == S_IDLE) begin
         ax = 40'(req_pos_x) <<< 14;
         ay = 40'(req_pos_y) <<< 14;
      end else begin
         ax = x_ff + 40'(dx_ff);
         ay = y_ff + 40'(dy_ff);
      end
      ex = ax + 40'sd4194303;
      ey = ay + 40'sd4194303;
      cx = ex >>> 22;
      cy = ey >>> 22;
      inb = !cx[39] && !cy[39] && (cx < 40'(xl)) && (cy < 40'(yl));
      raddr = AW'(cx) * AW'(WPC) + AW'(cy >>> 5);
   end

   logic acc;
   assign req_stall = (st_ff != S_IDLE);
   assign acc = req_valid && !req_stall;

   always_comb begin
      st_in = st_ff; px_in = px_ff; py_in = py_ff; hd_in = hd_ff; tag_in = tag_ff;
      ok_in = ok_ff; beam_in = beam_ff; x_in = x_ff; y_in = y_ff;
      dx_in = dx_ff; dy_in = dy_ff; dist_in = dist_ff; rng_in = rng_ff;
      hit_in = hit_ff; bit_in = bit_ff; cstart = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (acc && req_type) begin
               px_in = req_pos_x; py_in = req_pos_y; hd_in = req_heading;
               tag_in = req_pose_tag; beam_in = 3'd0; ok_in = inb;
               bit_in = cy[4:0];
               st_in = S_PCHK;
            end
         end
         S_PCHK: st_in = S_READ;  // reuse read/test path for the pose cell
         S_CORD: begin
            if (cdone) st_in = S_SETUP;
         end
         S_SETUP: begin
            dx_in = 28'(ccos) * 28'(stp);
            dy_in = 28'(csin) * 28'(stp);
            x_in = 40'(px_ff) <<< 14;
            y_in = 40'(py_ff) <<< 14;
            dist_in = 19'd0;
            st_in = S_MARCH;
         end
         S_MARCH: begin
            if (dist_ff > 19'(maxr_ff)) begin
               st_in = S_OUT;
            end else begin
               x_in = x_ff + 40'(dx_ff);
               y_in = y_ff + 40'(dy_ff);
               dist_in = dist_ff + 19'(stp);
               bit_in = cy[4:0];
               st_in = inb ? S_READ : S_OUT;
            end
         end
         S_READ: st_in = S_TEST;
         S_TEST: begin
            if (!cstart_seen_ff) begin
               // pose cell check
               if (rd_ff[5'd31 - bit_ff]) ok_in = 1'b0;
               st_in = S_OUT;
               if (ok_ff && !rd_ff[5'd31 - bit_ff]) begin
                  cstart = 1'b1; st_in = S_CORD;
               end
            end else if (rd_ff[5'd31 - bit_ff]) begin
               rng_in = dist_ff[17:0]; hit_in = 1'b1; st_in = S_OUT;
            end else begin
               st_in = S_MARCH;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rng_in = 18'd0; hit_in = 1'b0;
               if (beam_ff == 3'(NUM_BEAMS - 1)) begin
                  st_in = S_IDLE;
               end else begin
                  beam_in = beam_ff + 3'd1;
                  if (ok_ff) begin
                     cstart = 1'b1; st_in = S_CORD;
                  end
               end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || st_ff == S_IDLE) cstart_seen_ff <= 1'b0;
      else if (cstart) cstart_seen_ff <= 1'b1;
   end

   // pose path: an invalid pose skips the read and goes straight to results
   logic [2:0] st_fix;
   always_comb begin
      st_fix = st_in;
      if (st_ff == S_IDLE && acc && req_type && !inb) st_fix = S_OUT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         step_ff <= 11'd256; maxr_ff <= 17'd30720;
         xlim_ff <= 10'd300; ylim_ff <= 9'd240;
         rng_ff <= 18'd0; hit_ff <= 1'b0;
      end else begin
         st_ff <= st_fix;
         rng_ff <= rng_in; hit_ff <= hit_in;
         if (csr_write) begin
            case (csr_index)
               CSR_STEP: step_ff <= csr_data[10:0];
               CSR_MAXR: maxr_ff <= csr_data;
               CSR_XLIM: xlim_ff <= csr_data[9:0];
               CSR_YLIM: ylim_ff <= csr_data[8:0];
               default: ;
            endcase
         end
      end
      px_ff <= px_in; py_ff <= py_in; hd_ff <= hd_in; tag_ff <= tag_in;
      ok_ff <= ok_in; beam_ff <= beam_in; x_ff <= x_in; y_ff <= y_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dist_ff <= dist_in; bit_ff <= bit_in;
   end

   // grid memory, one write port and one read port
   logic [AW-1:0] ra_ff;
   always_ff @(posedge clock) begin
      if (acc && !req_type && 32'(req_map_addr) < 32'(GRID_WORDS))
         grid[AW'(req_map_addr)] <= req_map_data;
      if ((st_ff == S_IDLE) || (st_ff == S_MARCH)) ra_ff <= raddr;
      rd_ff <= grid[ra_ff];
   end

   assign rsp_valid      = (st_ff == S_OUT);
   assign rsp_tag_out    = tag_ff;
   assign rsp_beam_index = beam_ff;
   assign rsp_beam_range = rng_ff;
   assign rsp_beam_hit   = hit_ff;
   assign rsp_last_beam  = (beam_ff == 3'(NUM_BEAMS - 1));
endmodule

// File: rtl/ogbrc_cordic.sv
// iterative cordic: one micro-rotation per cycle, quadrant fold at the end
// depends on ogbrc_pkg
module ogbrc_cordic import ogbrc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        angle,
   output logic               done,
   output logic signed [15:0] cos_out,
   output logic signed [15:0] sin_out
);
   logic signed [15:0] x_ff, x_in, y_ff, y_in;
   logic signed [16:0] z_ff, z_in;
   logic [1:0]         q_ff, q_in;
   logic [3:0]         i_ff, i_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic signed [15:0] xs, ys;

   always_comb begin
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; q_in = q_ff; i_in = i_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         x_in = 16'sd9949; y_in = 16'sd0;
         z_in = {3'b000, angle[13:0]}; q_in = angle[15:14];
         i_in = 4'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[16]) begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - 17'(cordic_atan(i_ff));
         end else begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + 17'(cordic_atan(i_ff));
         end
         i_in = i_ff + 4'd1;
         if (i_ff == CORDIC_ITERS - 4'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; q_ff <= q_in; i_ff <= i_in;
   end

   assign done = done_ff;
   always_comb begin
      case (q_ff)
         2'd0: begin cos_out = x_ff;  sin_out = y_ff;  end
         2'd1: begin cos_out = -y_ff; sin_out = x_ff;  end
         2'd2: begin cos_out = -x_ff; sin_out = -y_ff; end
         default: begin cos_out = y_ff; sin_out = -x_ff; end
      endcase
   end
endmodule

// File: rtl/ogbrc_checker.sv
// port-level checks for the ray caster core
// bound to occupancy_grid_beam_ray_caster_core
module ogbrc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_beam_index,
   input logic [17:0] rsp_beam_range,
   input logic       rsp_beam_hit,
   input logic       rsp_last_beam
);
   // a result shows only while the block is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("result while ready");
   // a miss has zero range
   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_beam_hit |-> rsp_beam_range == 18'd0) else $error("miss range");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beam_index))
      else $error("result dropped");
   // after the last beam transfers the block is ready
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_beam |=> !req_stall) else $error("not ready");
endmodule

bind occupancy_grid_beam_ray_caster_core ogbrc_checker u_chk (.*);
